// ===== rtl/core/rhss_pkg.sv =====
package rhss_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;
  localparam int HASH_BITS_DEF   = 32;

  localparam int DIGIT_SHIFT = 7;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;

  localparam int PLEN_W  = 5;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int START_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

  typedef struct packed {
    logic shift;
    logic win_act;
    logic pat_act;
  } cell_ctl_t;

  function automatic logic [7:0] pat_char(input logic [CFG_W-1:0] low,
                                          input logic [CFG_W-1:0] high,
                                          input logic [3:0] idx);
    logic [CFG_W-1:0] w;
    w = idx[3] ? high : low;
    w = w >> {idx[2:0], 3'b000};
    return w[7:0];
  endfunction

endpackage

// ===== rtl/core/rhss_if.sv =====
interface rhss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface rhss_out_if;
  logic        valid;
  logic        ready;
  logic        window_match;
  logic [15:0] match_start;
  logic        any_found;
  logic        text_done;

  modport source (output valid, output window_match, output match_start,
                  output any_found, output text_done, input ready);
  modport sink   (input valid, input window_match, input match_start,
                  input any_found, input text_done, output ready);
endinterface

// ===== rtl/core/rhss_cell.sv =====
module rhss_cell
  import rhss_pkg::*;
#(
  parameter int K         = 0,
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [7:0]           din,
  input  logic [7:0]           pat_ch,
  output logic [7:0]           dout,
  output logic                 eq,
  output logic [HASH_BITS-1:0] win_term,
  output logic [HASH_BITS-1:0] pat_term
);

  logic [7:0]           byte_r;
  logic [7:0]           byte_nxt;
  logic [HASH_BITS-1:0] win_d;
  logic [HASH_BITS-1:0] pat_d;

  assign byte_nxt = ctl.shift ? din : byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign dout  = byte_r;
  assign eq    = !ctl.pat_act || (byte_r == pat_ch);
  assign win_d = HASH_BITS'(byte_r) - HASH_BITS'(DIGIT_ZERO);
  assign pat_d = HASH_BITS'(pat_ch) - HASH_BITS'(DIGIT_ZERO);

  // digit weight 128^K, wraps to zero once past the hash width
  assign win_term = ctl.win_act ? (win_d << (DIGIT_SHIFT * K)) : '0;
  assign pat_term = ctl.pat_act ? (pat_d << (DIGIT_SHIFT * K)) : '0;

endmodule

// ===== rtl/core/rolling_hash_substring_search.sv =====
// Result path: window cells, then output register, between input beat and result beat.
// Throughput: one text byte per cycle; the cell row shifts once per accepted beat.
// Backpressure on the result side stalls the whole row; input ready follows it.
// Reset (sync, active low) clears window, counters and flags and sets
// pattern_len to 1 with an all-zero pattern; the pattern hash register reloads every clock.
module rolling_hash_substring_search
  import rhss_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int HASH_BITS   = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rhss_in_if.sink              in_ch,
  rhss_out_if.source           out_ch
);

  localparam int SX_W = INDEX_BITS + START_W;

  logic [PLEN_W-1:0]     plen_r;
  logic [CFG_W-1:0]      plow_r;
  logic [CFG_W-1:0]      phigh_r;
  logic [HASH_BITS-1:0]  phash_r;
  logic [HASH_BITS-1:0]  phash_nxt;

  logic [INDEX_BITS-1:0] cnt_r;
  logic [INDEX_BITS-1:0] cnt_nxt;
  logic                  last_seen_r;
  logic                  s1_valid_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic [INDEX_BITS-1:0] idx_use;
  logic                  s1_last_r;
  logic                  found_r;

  logic                  out_valid_r;
  logic                  out_match_r;
  logic [START_W-1:0]    out_start_r;
  logic                  out_found_r;
  logic                  out_done_r;

  logic                  advance;
  logic                  in_acc;
  logic [PLEN_W-1:0]     eff_len;
  logic [3:0]            len_m1;
  logic                  len_ok;
  logic                  hash_eq;
  logic                  bytes_eq;
  logic                  match;
  logic [INDEX_BITS-1:0] start_idx;
  logic [SX_W-1:0]       start_ext;
  logic [HASH_BITS-1:0]  win_sum;

  cell_ctl_t             ctl      [MAX_PATTERN];
  logic [7:0]            cell_in  [MAX_PATTERN];
  logic [7:0]            cell_out [MAX_PATTERN];
  logic [7:0]            pal      [MAX_PATTERN];
  logic                  cell_eq  [MAX_PATTERN];
  logic [HASH_BITS-1:0]  wterm    [MAX_PATTERN];
  logic [HASH_BITS-1:0]  pterm    [MAX_PATTERN];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= PLEN_W'(1);
      plow_r  <= '0;
      phigh_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LEN:  plen_r  <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_LOW:  plow_r  <= cfg_data;
        REG_PATTERN_HIGH: phigh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plen_r == '0) begin
      eff_len = PLEN_W'(1);
    end else if (plen_r > PLEN_W'(MAX_PATTERN)) begin
      eff_len = PLEN_W'(MAX_PATTERN);
    end else begin
      eff_len = plen_r;
    end
  end

  assign len_m1 = 4'(eff_len - PLEN_W'(1));

  // handshake
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign in_acc       = in_ch.valid && advance;

  assign idx_use = last_seen_r ? '0 : cnt_r;
  assign cnt_nxt = (idx_use == '1) ? idx_use : idx_use + INDEX_BITS'(1);

  // cell row
  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
        assign cell_in[k] = in_ch.text_char;
      end else begin : g_link
        assign cell_in[k] = cell_out[k-1];
      end

      always_comb begin
        ctl[k].shift   = in_acc;
        ctl[k].pat_act = PLEN_W'(k) < eff_len;
        ctl[k].win_act = ctl[k].pat_act && (s1_idx_r >= INDEX_BITS'(k));
        pal[k] = pat_char(plow_r, phigh_r, 4'(len_m1 - 4'(k)));
      end

      rhss_cell #(
        .K         (k),
        .HASH_BITS (HASH_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[k]),
        .din      (cell_in[k]),
        .pat_ch   (pal[k]),
        .dout     (cell_out[k]),
        .eq       (cell_eq[k]),
        .win_term (wterm[k]),
        .pat_term (pterm[k])
      );
    end
  endgenerate

  always_comb begin
    win_sum   = '0;
    phash_nxt = '0;
    bytes_eq  = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_sum   = win_sum + wterm[i];
      phash_nxt = phash_nxt + pterm[i];
      bytes_eq  = bytes_eq && cell_eq[i];
    end
  end

  always_ff @(posedge clk) begin
    phash_r <= phash_nxt;
  end

  assign len_ok    = s1_idx_r >= INDEX_BITS'(len_m1);
  assign hash_eq   = win_sum == phash_r;
  assign match     = s1_valid_r && len_ok && hash_eq && bytes_eq;
  assign start_idx = match ? (s1_idx_r - INDEX_BITS'(len_m1)) : '0;
  assign start_ext = SX_W'(start_idx);

  // stream state and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      last_seen_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_idx_r    <= '0;
      s1_last_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r       <= cnt_nxt;
        last_seen_r <= in_ch.last_char;
        s1_idx_r    <= idx_use;
        s1_last_r   <= in_ch.last_char;
      end
      if (advance) begin
        s1_valid_r  <= in_acc;
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          found_r <= s1_last_r ? 1'b0 : (found_r || match);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_match_r <= match;
      out_start_r <= start_ext[START_W-1:0];
      out_found_r <= found_r || match;
      out_done_r  <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_match = out_match_r;
  assign out_ch.match_start  = out_start_r;
  assign out_ch.any_found    = out_found_r;
  assign out_ch.text_done    = out_done_r;

  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_match_r |-> out_found_r)
    else $error("match reported without sticky flag");

  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    match |-> len_ok && bytes_eq)
    else $error("match on a short or unequal window");

  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_seen_r |=> s1_idx_r == '0)
    else $error("new text did not restart at index zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(s1_idx_r) && $stable(s1_valid_r) && $stable(cell_out[0]))
    else $error("window moved during output stall");

  a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_last_r |=> !found_r)
    else $error("sticky flag survived end of text");

endmodule
